>>> hdl/hamming_sec_encode_decode_macros.svh
// Assertion macros shared by the coder RTL.
// Define ASSERT_OFF to compile all checks out.
`ifndef HAMMING_SEC_ENCODE_DECODE_MACROS_SVH
`define HAMMING_SEC_ENCODE_DECODE_MACROS_SVH
`ifndef ASSERT_OFF
// checked only while reset is low
`define HSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define HSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HSC_ASSERT(label, prop, msg)
`define HSC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hdl/hsc_pkg.sv
`default_nettype none
package hsc_pkg;

   // fixed field widths
   localparam int WORD_W     = 64;
   localparam int DLEN_W     = 6;
   localparam int CLEN_W     = 7;
   localparam int PCNT_W     = 3;
   localparam int SYN_W      = 7;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int RSP_DATA_W = 80;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DATA_BITS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_BITS = 8'd1;

   // reset values
   localparam logic [DLEN_W-1:0] DATA_BITS_RST = 6'd4;
   localparam logic [CLEN_W-1:0] CODE_BITS_RST = 7'd7;

   // effective lengths handed to the datapath
   typedef struct packed {
      logic [DLEN_W-1:0] data_len;
      logic [PCNT_W-1:0] enc_pcount;
      logic [CLEN_W-1:0] code_len;
      logic [PCNT_W-1:0] dec_pcount;
   } cfg_type;

   // one result item, word_out in the low bits
   typedef struct packed {
      logic              out_of_range;
      logic              corrected;
      logic [SYN_W-1:0]  syndrome;
      logic [PCNT_W-1:0] parity_count;
      logic [WORD_W-1:0] word_out;
   } rsp_type;

   // least c with k + c + 1 <= 2^c
   function automatic logic [PCNT_W-1:0] enc_parity(input logic [DLEN_W-1:0] k);
      int c;
      c = 7;
      for (int s = 7; s >= 0; s--) begin
         if (int'(k) + s + 1 <= (1 << s)) c = s;
      end
      return PCNT_W'(c);
   endfunction

   // number of significant bits of a code length
   function automatic logic [PCNT_W-1:0] bit_length(input logic [CLEN_W-1:0] n);
      int c;
      c = 0;
      for (int s = 0; s < CLEN_W; s++) begin
         if (n[s]) c = s + 1;
      end
      return PCNT_W'(c);
   endfunction

   // longest data word whose codeword fits in max_code positions
   function automatic logic [DLEN_W-1:0] max_data_len(input int max_code);
      int r;
      r = 0;
      for (int k = 0; k < (1 << DLEN_W); k++) begin
         if (k + int'(enc_parity(DLEN_W'(k))) <= max_code) r = k;
      end
      return DLEN_W'(r);
   endfunction

   // floor(log2 i) for positions 1..64
   function automatic int msb_pos(input int i);
      int r;
      r = 0;
      for (int s = 0; s < 8; s++) begin
         if ((i >> s) != 0) r = s;
      end
      return r;
   endfunction

   // data bit index that lands at a non-power-of-two position
   function automatic int data_idx(input int i);
      return i - msb_pos(i) - 2;
   endfunction

   function automatic bit is_pow2(input int i);
      return (i & (i - 1)) == 0;
   endfunction

   // positions i (bit i-1) whose index has bit j set
   function automatic logic [WORD_W-1:0] pos_mask(input int j);
      logic [WORD_W-1:0] m;
      for (int i = 1; i <= WORD_W; i++) begin
         m[i-1] = ((i >> j) & 1) != 0;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

>>> hdl/hsc_config.sv
`default_nettype none
module hsc_config #(
   parameter int MAX_CODE_BITS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [hsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output hsc_pkg::cfg_type                        cfg
);

   localparam logic [hsc_pkg::DLEN_W-1:0] MAX_DLEN = hsc_pkg::max_data_len(MAX_CODE_BITS);
   localparam logic [hsc_pkg::CLEN_W-1:0] MAX_CLEN = hsc_pkg::CLEN_W'(MAX_CODE_BITS);

   logic [hsc_pkg::DLEN_W-1:0] data_bits_ff;
   logic [hsc_pkg::CLEN_W-1:0] code_bits_ff;
   logic [hsc_pkg::DLEN_W-1:0] data_len;
   logic [hsc_pkg::CLEN_W-1:0] code_len;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= hsc_pkg::DATA_BITS_RST;
         code_bits_ff <= hsc_pkg::CODE_BITS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            hsc_pkg::REG_DATA_BITS: data_bits_ff <= csr_wdata[hsc_pkg::DLEN_W-1:0];
            hsc_pkg::REG_CODE_BITS: code_bits_ff <= csr_wdata[hsc_pkg::CLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp lengths to what the codeword can hold
   always_comb begin
      data_len = (data_bits_ff > MAX_DLEN) ? MAX_DLEN : data_bits_ff;
      code_len = (code_bits_ff > MAX_CLEN) ? MAX_CLEN : code_bits_ff;
      cfg.data_len   = data_len;
      cfg.enc_pcount = hsc_pkg::enc_parity(data_len);
      cfg.code_len   = code_len;
      cfg.dec_pcount = hsc_pkg::bit_length(code_len);
   end

endmodule
`default_nettype wire

>>> hdl/hsc_encoder.sv
`default_nettype none
module hsc_encoder #(
   parameter int MAX_CODE_BITS = 64
) (
   input  wire logic [hsc_pkg::WORD_W-1:0]  word_in,
   input  wire logic [hsc_pkg::DLEN_W-1:0]  data_len,
   output logic      [hsc_pkg::WORD_W-1:0]  code_word
);

   localparam int W = hsc_pkg::WORD_W;

   logic [W-1:0]               data_masked;
   logic [W-1:0]               placed;
   logic [hsc_pkg::SYN_W-1:0]  parity;

   // drop data bits above the configured length
   always_comb begin
      for (int b = 0; b < W; b++) begin
         data_masked[b] = word_in[b] & (b < int'(data_len));
      end
   end

   // data bits go to the non-power-of-two positions
   for (genvar i = 1; i <= W; i++) begin : g_place
      if (i > MAX_CODE_BITS || hsc_pkg::is_pow2(i)) begin : g_zero
         assign placed[i-1] = 1'b0;
      end else begin : g_data
         assign placed[i-1] = data_masked[hsc_pkg::data_idx(i)];
      end
   end

   // parity j covers positions with index bit j set
   for (genvar j = 0; j < hsc_pkg::SYN_W; j++) begin : g_par
      assign parity[j] = ^(placed & hsc_pkg::pos_mask(j));
   end

   // merge parity bits into their power-of-two slots
   for (genvar i = 1; i <= W; i++) begin : g_out
      if (i <= MAX_CODE_BITS && hsc_pkg::is_pow2(i)) begin : g_p
         assign code_word[i-1] = parity[hsc_pkg::msb_pos(i)];
      end else begin : g_d
         assign code_word[i-1] = placed[i-1];
      end
   end

endmodule
`default_nettype wire

>>> hdl/hsc_decoder.sv
`default_nettype none
module hsc_decoder (
   input  wire logic [hsc_pkg::WORD_W-1:0]  word_in,
   input  wire logic [hsc_pkg::CLEN_W-1:0]  code_len,
   output logic      [hsc_pkg::WORD_W-1:0]  word_out,
   output logic      [hsc_pkg::SYN_W-1:0]   syndrome,
   output logic                             corrected,
   output logic                             out_of_range
);

   localparam int W = hsc_pkg::WORD_W;

   logic [W-1:0] masked;
   logic [W-1:0] flip;
   logic         in_range;
   logic         nonzero;

   // keep only positions inside the codeword
   always_comb begin
      for (int b = 0; b < W; b++) begin
         masked[b] = word_in[b] & (b < int'(code_len));
      end
   end

   // syndrome bit j: parity over positions with index bit j set
   for (genvar j = 0; j < hsc_pkg::SYN_W; j++) begin : g_syn
      assign syndrome[j] = ^(masked & hsc_pkg::pos_mask(j));
   end

   assign nonzero      = syndrome != '0;
   assign in_range     = syndrome <= code_len;
   assign corrected    = nonzero & in_range;
   assign out_of_range = nonzero & ~in_range;

   // one-hot flip at the syndrome position
   always_comb begin
      for (int b = 0; b < W; b++) begin
         flip[b] = corrected && (syndrome == hsc_pkg::SYN_W'(b + 1));
      end
   end

   assign word_out = masked ^ flip;

endmodule
`default_nettype wire

>>> hdl/hamming_sec_encode_decode.sv
// Single-error-correcting Hamming coder, even parity, configurable length.
// req_ channel: one item per handshake; tuser selects encode (0) or
//   check-and-correct (1), tdata carries the data word or codeword.
// rsp_ channel: one result item per request item, in order.
// csr_ channel: writes data_bits (index 0) and code_bits (index 1); always
//   ready; the user must see that it is written only while no item is in flight (not enforced).
// Datapath: an accepted item is captured in the input register, coded by
//   XOR trees and a fixed bit-placement network, and lands in the result
//   register, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_tready stays high, set by the two-register pipeline.
// Reset clears both pipeline valids and loads data_bits 4, code_bits 7;
//   no clearing pass is needed.
// When the receiver stalls, the result register holds and the input
//   register still takes one more item; req_tready then drops until
//   rsp_tready returns.
`default_nettype none
`include "hamming_sec_encode_decode_macros.svh"
module hamming_sec_encode_decode #(
   parameter int MAX_CODE_BITS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // fields: word_in[63:0]
   input  wire logic [hsc_pkg::WORD_W-1:0]         req_tdata,
   // fields: mode[0]
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // fields: word_out[63:0], parity_count[66:64], syndrome[73:67],
   //         corrected[74], out_of_range[75], zero fill[79:76]
   output logic [hsc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [hsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FILL_W = hsc_pkg::RSP_DATA_W - $bits(hsc_pkg::rsp_type);

   hsc_pkg::cfg_type cfg;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_mode_ff;
   logic [hsc_pkg::WORD_W-1:0]    s1_word_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   hsc_pkg::rsp_type              rsp_ff;
   hsc_pkg::rsp_type              rsp_in;
   logic                          req_fire;
   logic                          rsp_load;

   logic [hsc_pkg::WORD_W-1:0]    enc_word;
   logic [hsc_pkg::WORD_W-1:0]    dec_word;
   logic [hsc_pkg::SYN_W-1:0]     dec_syn;
   logic                          dec_corr;
   logic                          dec_oor;

   logic                          rsp_both_flags;
   logic                          rsp_corr_zero;
   logic                          enc_load;
   logic                          rsp_status_idle;

   hsc_config #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsc_encoder #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_encoder (
      .word_in   (s1_word_ff),
      .data_len  (cfg.data_len),
      .code_word (enc_word)
   );

   hsc_decoder u_decoder (
      .word_in      (s1_word_ff),
      .code_len     (cfg.code_len),
      .word_out     (dec_word),
      .syndrome     (dec_syn),
      .corrected    (dec_corr),
      .out_of_range (dec_oor)
   );

   // pipeline flow control
   assign rsp_load   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | rsp_load;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;
   end

   // result select
   always_comb begin
      if (s1_mode_ff) begin
         rsp_in.word_out     = dec_word;
         rsp_in.parity_count = cfg.dec_pcount;
         rsp_in.syndrome     = dec_syn;
         rsp_in.corrected    = dec_corr;
         rsp_in.out_of_range = dec_oor;
      end else begin
         rsp_in.word_out     = enc_word;
         rsp_in.parity_count = cfg.enc_pcount;
         rsp_in.syndrome     = '0;
         rsp_in.corrected    = 1'b0;
         rsp_in.out_of_range = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_tuser;
         s1_word_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{FILL_W{1'b0}}, rsp_ff};

   // terms used by the checks
   assign rsp_both_flags  = rsp_ff.corrected & rsp_ff.out_of_range;
   assign rsp_corr_zero   = rsp_ff.corrected & (rsp_ff.syndrome == '0);
   assign enc_load        = rsp_load & s1_valid_ff & ~s1_mode_ff;
   assign rsp_status_idle = (rsp_ff.syndrome == '0) & ~rsp_ff.corrected
                            & ~rsp_ff.out_of_range;

   // checks
   `HSC_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid_ff && !s1_valid_ff), "valid after reset")
   `HSC_ASSERT(a_flags_excl, rsp_valid_ff |-> !rsp_both_flags, "both flags set")
   `HSC_ASSERT(a_corr_syn, rsp_valid_ff |-> !rsp_corr_zero, "corrected with zero syndrome")
   `HSC_ASSERT(a_enc_clean, enc_load |=> rsp_status_idle, "encode result carries decode status")
   `HSC_ASSERT(a_ready_free, !rsp_valid_ff |-> req_tready, "input blocked with empty output")

endmodule
`default_nettype wire
